### rtl/priority_round_robin_task_scheduler_macros.svh
// Assertion macros for the priority round-robin task scheduler.
// Depends on nothing; included by the files that carry assertions.
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define PRRTS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define PRRTS_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define PRRTS_ASSERT(label, clk, rst_n, prop)
`define PRRTS_ASSERT_RST(label, clk, prop)
`endif
`endif

### rtl/prrts_pkg.sv
// Package of the priority round-robin task scheduler: widths, codes, types.
// Depends on nothing.
package prrts_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned PidWidth   = 16;

  localparam logic [15:0] AgingTickReset = 16'd20;
  localparam logic [7:0]  DefPrioReset   = 8'd128;
  localparam logic [7:0]  PrioNone       = 8'd255;
  localparam logic [7:0]  PrioAged       = 8'd1;
  localparam logic [15:0] TickMax        = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_TICK = 3'd0, OP_ADD = 3'd1, OP_FORK = 3'd2,
    OP_EXIT = 3'd3, OP_WAIT = 3'd4, OP_SETP = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_READY = 2'd0, ST_RUNNING = 2'd1, ST_BLOCKED = 2'd2, ST_TERM = 2'd3
  } tstate_e;

  typedef enum logic [1:0] {
    RS_OK = 2'd0, RS_FULL = 2'd1, RS_NOTFOUND = 2'd2, RS_NONE = 2'd3
  } rstat_e;

  localparam logic [1:0] CfgAgingPid = 2'd0;
  localparam logic [1:0] CfgAgingTick = 2'd1;
  localparam logic [1:0] CfgDefPrio = 2'd2;

  // Payloads of the request and response channels.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] target_pid;
    logic [7:0]  priority_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  running_index;
    logic [15:0] running_pid;
    logic [15:0] return_value;
  } rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_FIND_REQ, S_FIND_WAIT, S_FIND_CHK,
    S_TK_CUR, S_TK_CURW, S_TK_CURCHK, S_TK_WAKE,
    S_TK_AGE, S_TK_AGEW, S_TK_AGECHK,
    S_SC_REQ, S_SC_WAIT, S_SC_CHK, S_SC_END,
    S_EX_RD, S_EX_RDW, S_EX_WCHK,
    S_WP_CHK, S_WP_CUR, S_WP_CURW, S_WP_SET,
    S_OUT_RD, S_OUT_RDW, S_RESP
  } fsm_e;

  typedef enum logic [1:0] {
    FP_TICK_WAKE, FP_TICK_AGE, FP_EXIT, FP_WAIT
  } fpurp_e;

endpackage

### rtl/prrts_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing; payload type is a parameter.
interface prrts_if #(
  parameter type payload_t = logic
) (
  input logic clk_i
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/priority_round_robin_task_scheduler.sv
// Top level of the priority round-robin task scheduler with aging.
// Depends on prrts_pkg, prrts_if and the macros header.
//
//   channel   direction  payload                                           handshake
//   req_if    in         opcode, target_pid, priority_value                valid/ready
//   rsp_if    out        status, running_index, running_pid, return_value  valid/ready
//   cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i                   write strobe
//
// The block takes one request at a time and is not ready while it works on it. Every
// table access goes through the entry memory, which has one write port and one read
// port with a registered read data, so a pid search steps each slot through a request,
// a wait and a check state, and a tick runs a best-priority scan that restarts after
// each improvement of the scan, plus up to two pid searches.
// Reset sets the configuration and control registers only; the table holds nothing defined until a
// task is created. A held response stalls the block until it is taken.
`include "priority_round_robin_task_scheduler_macros.svh"

module priority_round_robin_task_scheduler #(
  parameter int unsigned TABLE_DEPTH = prrts_pkg::TableDepth,
  parameter int unsigned PID_WIDTH   = prrts_pkg::PidWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  prrts_if.sink       req_if,
  prrts_if.source     rsp_if
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // One table row: pid, state, priority, waiter valid and waiter pid.
  typedef struct packed {
    logic [PID_WIDTH-1:0] pid;
    logic [1:0]           st;
    logic [7:0]           prio;
    logic                 wv;
    logic [PID_WIDTH-1:0] wpid;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;
  entry_t        mem_wd, rd_q;

  // The read data is held until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Configuration registers.
  logic [15:0] aging_pid_q, aging_tick_q;
  logic [7:0]  def_prio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aging_pid_q  <= '0;
      aging_tick_q <= prrts_pkg::AgingTickReset;
      def_prio_q   <= prrts_pkg::DefPrioReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prrts_pkg::CfgAgingPid:  aging_pid_q  <= cfg_data_i;
        prrts_pkg::CfgAgingTick: aging_tick_q <= cfg_data_i;
        prrts_pkg::CfgDefPrio:   def_prio_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Control and work registers.
  prrts_pkg::fsm_e   st_q, st_d;
  prrts_pkg::fpurp_e purp_q, purp_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              cv_q, cv_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [PID_WIDTH-1:0] pidc_q, pidc_d;
  logic [15:0]       tick_q, tick_d;
  logic [2:0]        op_q, op_d;
  logic [PID_WIDTH-1:0] key_q, key_d;
  logic [7:0]        pv_q, pv_d;
  logic [IW-1:0]     idx_q, idx_d, best_i_q, best_i_d, fnd_q, fnd_d;
  logic [CW-1:0]     i_q, i_d;
  logic [7:0]        best_q, best_d;
  logic [1:0]        stat_q, stat_d;
  logic [15:0]       ret_q, ret_d;
  logic [PID_WIDTH-1:0] curpid_q, curpid_d;
  logic [7:0]        oidx_q, oidx_d;
  logic [15:0]       opid_q, opid_d;
  logic              ovalid_q, ovalid_d;
  entry_t            hold_q, hold_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= prrts_pkg::S_IDLE; cnt_q <= '0; cv_q <= 1'b0; cur_q <= '0;
      pidc_q <= '0; tick_q <= '0; ovalid_q <= 1'b0; purp_q <= prrts_pkg::FP_EXIT;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; cv_q <= cv_d; cur_q <= cur_d;
      pidc_q <= pidc_d; tick_q <= tick_d; ovalid_q <= ovalid_d; purp_q <= purp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; key_q <= key_d; pv_q <= pv_d; idx_q <= idx_d; best_i_q <= best_i_d;
    fnd_q <= fnd_d; i_q <= i_d; best_q <= best_d; stat_q <= stat_d; ret_q <= ret_d;
    curpid_q <= curpid_d; oidx_q <= oidx_d; opid_q <= opid_d; hold_q <= hold_d;
  end

  // Advance a slot index circularly over the live part of the table.
  function automatic logic [IW-1:0] nxt(input logic [IW-1:0] a, input logic [CW-1:0] n);
    logic [CW-1:0] b;
    b = CW'(a) + CW'(1);
    return (b >= n) ? '0 : b[IW-1:0];
  endfunction

  always_comb begin
    st_d = st_q; purp_d = purp_q; cnt_d = cnt_q; cv_d = cv_q; cur_d = cur_q;
    pidc_d = pidc_q; tick_d = tick_q; op_d = op_q; key_d = key_q; pv_d = pv_q;
    idx_d = idx_q; best_i_d = best_i_q; fnd_d = fnd_q; i_d = i_q; best_d = best_q;
    stat_d = stat_q; ret_d = ret_q; curpid_d = curpid_q; oidx_d = oidx_q;
    opid_d = opid_q; ovalid_d = ovalid_q; hold_d = hold_q;
    mem_we = 1'b0; mem_wa = idx_q; mem_wd = rd_q; mem_ra = idx_q; mem_re = 1'b0;
    req_if.ready = 1'b0;

    if (ovalid_q && rsp_if.ready) ovalid_d = 1'b0;

    unique case (st_q)
      prrts_pkg::S_IDLE: begin
        req_if.ready = !ovalid_q;
        if (req_if.valid && !ovalid_q) begin
          op_d = req_if.payload.opcode;
          key_d = PID_WIDTH'(req_if.payload.target_pid);
          pv_d = req_if.payload.priority_value;
          stat_d = prrts_pkg::RS_OK; ret_d = '0;
          st_d = prrts_pkg::S_DECODE;
        end
      end
      prrts_pkg::S_DECODE: begin
        st_d = prrts_pkg::S_OUT_RD;
        unique case (op_q)
          prrts_pkg::OP_TICK: begin
            if (cnt_q == '0) stat_d = prrts_pkg::RS_NONE;
            else if (cv_q) begin idx_d = cur_q; st_d = prrts_pkg::S_TK_CUR; end
            else st_d = prrts_pkg::S_TK_AGE;
          end
          prrts_pkg::OP_ADD, prrts_pkg::OP_FORK: begin
            if (op_q == prrts_pkg::OP_FORK && !cv_q) stat_d = prrts_pkg::RS_NONE;
            else if (cnt_q >= CW'(TABLE_DEPTH)) stat_d = prrts_pkg::RS_FULL;
            else begin
              mem_we = 1'b1; mem_wa = cnt_q[IW-1:0];
              mem_wd = '{pid: pidc_q, st: prrts_pkg::ST_READY, prio: def_prio_q,
                         wv: 1'b0, wpid: '0};
              ret_d = 16'(pidc_q); cnt_d = cnt_q + CW'(1);
              pidc_d = pidc_q + PID_WIDTH'(1);
            end
          end
          prrts_pkg::OP_EXIT: begin
            if (!cv_q) stat_d = prrts_pkg::RS_NONE;
            else begin idx_d = cur_q; st_d = prrts_pkg::S_EX_RD; end
          end
          prrts_pkg::OP_WAIT: begin
            purp_d = prrts_pkg::FP_WAIT; i_d = '0; st_d = prrts_pkg::S_FIND_REQ;
          end
          prrts_pkg::OP_SETP: begin
            if (!cv_q) stat_d = prrts_pkg::RS_NONE;
            else begin idx_d = cur_q; st_d = prrts_pkg::S_SC_END; best_d = 8'd0; end
          end
          default: ;
        endcase
      end
      // Linear pid search: key_q against slots 0..cnt-1, lowest match wins.
      prrts_pkg::S_FIND_REQ: begin
        if (i_q >= cnt_q) begin
          unique case (purp_q)
            prrts_pkg::FP_WAIT: begin stat_d = prrts_pkg::RS_NOTFOUND;
              st_d = prrts_pkg::S_OUT_RD; end
            prrts_pkg::FP_TICK_WAKE: st_d = prrts_pkg::S_TK_AGE;
            prrts_pkg::FP_TICK_AGE: st_d = prrts_pkg::S_SC_REQ;
            default: st_d = prrts_pkg::S_OUT_RD;
          endcase
          if (purp_q == prrts_pkg::FP_TICK_AGE) begin
            best_d = prrts_pkg::PrioNone; best_i_d = cur_q; i_d = '0;
            idx_d = cv_q ? nxt(cur_q, cnt_q) : '0;
          end
        end else begin
          mem_re = 1'b1; mem_ra = i_q[IW-1:0]; st_d = prrts_pkg::S_FIND_WAIT;
        end
      end
      prrts_pkg::S_FIND_WAIT: st_d = prrts_pkg::S_FIND_CHK;
      prrts_pkg::S_FIND_CHK: begin
        if (rd_q.pid == key_q) begin
          fnd_d = i_q[IW-1:0]; hold_d = rd_q;
          unique case (purp_q)
            prrts_pkg::FP_TICK_WAKE: begin
              mem_we = 1'b1; mem_wa = i_q[IW-1:0]; mem_wd = rd_q;
              mem_wd.st = prrts_pkg::ST_READY; st_d = prrts_pkg::S_TK_AGE;
            end
            prrts_pkg::FP_TICK_AGE: begin
              if (rd_q.st != prrts_pkg::ST_TERM) begin
                mem_we = 1'b1; mem_wa = i_q[IW-1:0]; mem_wd = rd_q;
                mem_wd.prio = prrts_pkg::PrioAged;
              end
              best_d = prrts_pkg::PrioNone; best_i_d = cur_q; i_d = '0;
              idx_d = cv_q ? nxt(cur_q, cnt_q) : '0;
              st_d = prrts_pkg::S_SC_REQ;
            end
            prrts_pkg::FP_EXIT: begin
              if (rd_q.st == prrts_pkg::ST_BLOCKED) begin
                mem_we = 1'b1; mem_wa = i_q[IW-1:0]; mem_wd = rd_q;
                mem_wd.st = prrts_pkg::ST_READY;
              end
              st_d = prrts_pkg::S_OUT_RD;
            end
            default: st_d = prrts_pkg::S_WP_CHK;
          endcase
        end else begin
          i_d = i_q + CW'(1); st_d = prrts_pkg::S_FIND_REQ;
        end
      end
      // Tick: wake the waiter of a terminated current task.
      prrts_pkg::S_TK_CUR: begin
        mem_re = 1'b1; mem_ra = cur_q; st_d = prrts_pkg::S_TK_CURW;
      end
      prrts_pkg::S_TK_CURW: st_d = prrts_pkg::S_TK_CURCHK;
      prrts_pkg::S_TK_CURCHK: begin
        if (rd_q.st == prrts_pkg::ST_TERM && rd_q.wv) begin
          key_d = rd_q.wpid; purp_d = prrts_pkg::FP_TICK_WAKE; i_d = '0;
          st_d = prrts_pkg::S_FIND_REQ;
        end else st_d = prrts_pkg::S_TK_AGE;
      end
      prrts_pkg::S_TK_WAKE: st_d = prrts_pkg::S_TK_AGE;
      prrts_pkg::S_TK_AGE: begin
        if (tick_q == aging_tick_q) begin
          key_d = PID_WIDTH'(aging_pid_q); purp_d = prrts_pkg::FP_TICK_AGE; i_d = '0;
          st_d = prrts_pkg::S_FIND_REQ;
        end else begin
          best_d = prrts_pkg::PrioNone; best_i_d = cur_q; i_d = '0;
          idx_d = cv_q ? nxt(cur_q, cnt_q) : '0;
          st_d = prrts_pkg::S_SC_REQ;
        end
      end
      prrts_pkg::S_TK_AGEW, prrts_pkg::S_TK_AGECHK: st_d = prrts_pkg::S_SC_REQ;
      // Circular best-priority scan that restarts after each improvement.
      prrts_pkg::S_SC_REQ: begin
        if (i_q >= cnt_q) begin
          cur_d = best_i_q; idx_d = best_i_q; st_d = prrts_pkg::S_SC_END;
        end else begin
          mem_re = 1'b1; mem_ra = idx_q; st_d = prrts_pkg::S_SC_WAIT;
        end
      end
      prrts_pkg::S_SC_WAIT: st_d = prrts_pkg::S_SC_CHK;
      prrts_pkg::S_SC_CHK: begin
        st_d = prrts_pkg::S_SC_REQ;
        idx_d = nxt(idx_q, cnt_q);
        if ((rd_q.st == prrts_pkg::ST_READY || rd_q.st == prrts_pkg::ST_RUNNING) &&
            rd_q.prio < best_q) begin
          best_d = rd_q.prio; best_i_d = idx_q; cv_d = 1'b1; i_d = '0;
        end else i_d = i_q + CW'(1);
      end
      // Read-modify-write of the current entry (tick end, set priority or exit).
      prrts_pkg::S_SC_END: begin
        mem_re = 1'b1; mem_ra = idx_q; st_d = prrts_pkg::S_EX_RDW; hold_d.wv = 1'b1;
      end
      prrts_pkg::S_EX_RD: begin
        mem_re = 1'b1; mem_ra = idx_q; st_d = prrts_pkg::S_EX_RDW; hold_d.wv = 1'b0;
      end
      prrts_pkg::S_EX_RDW: st_d = prrts_pkg::S_EX_WCHK;
      prrts_pkg::S_EX_WCHK: begin
        st_d = prrts_pkg::S_OUT_RD;
        mem_wa = idx_q; mem_wd = rd_q;
        if (op_q == prrts_pkg::OP_TICK) begin
          if (cv_q) begin mem_we = 1'b1; mem_wd.st = prrts_pkg::ST_RUNNING; end
          else stat_d = prrts_pkg::RS_NONE;
          if (tick_q != prrts_pkg::TickMax) tick_d = tick_q + 16'd1;
        end else if (op_q == prrts_pkg::OP_SETP) begin
          mem_we = 1'b1; mem_wd.prio = pv_q;
        end else begin
          mem_we = 1'b1; mem_wd.st = prrts_pkg::ST_TERM;
          if (rd_q.wv) begin
            key_d = rd_q.wpid; purp_d = prrts_pkg::FP_EXIT; i_d = '0;
            st_d = prrts_pkg::S_FIND_REQ;
          end
        end
      end
      // Waitpid after the target is found.
      prrts_pkg::S_WP_CHK: begin
        st_d = prrts_pkg::S_OUT_RD;
        if (hold_q.st == prrts_pkg::ST_TERM) stat_d = prrts_pkg::RS_OK;
        else if (!cv_q) stat_d = prrts_pkg::RS_NONE;
        else begin mem_re = 1'b1; mem_ra = cur_q; st_d = prrts_pkg::S_WP_CUR; end
      end
      prrts_pkg::S_WP_CUR: st_d = prrts_pkg::S_WP_CURW;
      prrts_pkg::S_WP_CURW: begin
        curpid_d = rd_q.pid;
        mem_we = 1'b1; mem_wa = cur_q; mem_wd = rd_q; mem_wd.st = prrts_pkg::ST_BLOCKED;
        st_d = prrts_pkg::S_WP_SET;
      end
      prrts_pkg::S_WP_SET: begin
        // Re-read target is unnecessary: if target is current, its row was just
        // changed, so rebuild it from the fresh state where they coincide.
        mem_we = 1'b1; mem_wa = fnd_q; mem_wd = hold_q;
        if (fnd_q == cur_q) mem_wd.st = prrts_pkg::ST_BLOCKED;
        mem_wd.wv = 1'b1; mem_wd.wpid = curpid_q;
        st_d = prrts_pkg::S_OUT_RD;
      end
      // Fetch the current pid for the response.
      prrts_pkg::S_OUT_RD: begin
        mem_re = 1'b1; mem_ra = cur_q; st_d = prrts_pkg::S_OUT_RDW;
      end
      prrts_pkg::S_OUT_RDW: st_d = prrts_pkg::S_RESP;
      prrts_pkg::S_RESP: begin
        if (!ovalid_q) begin
          oidx_d = cv_q ? 8'(cur_q) : 8'd0;
          opid_d = cv_q ? 16'(rd_q.pid) : 16'd0;
          ovalid_d = 1'b1; st_d = prrts_pkg::S_IDLE;
        end
      end
      default: st_d = prrts_pkg::S_IDLE;
    endcase
  end

  assign rsp_if.valid = ovalid_q;
  assign rsp_if.payload.status = stat_q;
  assign rsp_if.payload.running_index = oidx_q;
  assign rsp_if.payload.running_pid = opid_q;
  assign rsp_if.payload.return_value = ret_q;

  `PRRTS_ASSERT(a_rdy_idle, clk_i, rst_ni, req_if.ready |-> (st_q == prrts_pkg::S_IDLE))
  `PRRTS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(TABLE_DEPTH))
  `PRRTS_ASSERT(a_cnt_mono, clk_i, rst_ni, cnt_q >= $past(cnt_q))
  `PRRTS_ASSERT(a_tick_sat, clk_i, rst_ni,
                ($past(tick_q) == prrts_pkg::TickMax) |-> (tick_q == prrts_pkg::TickMax))

endmodule
